// ===== hw/rtl/ucb_pkg.sv =====
// Shared types, constants and the log table for the UCB1 child selector.
// No dependencies; imported by every module of the block.
package ucb_pkg;

    // Stream and field sizes
    localparam int MAX_CHILDREN = 1024;
    localparam int POS_W        = $clog2(MAX_CHILDREN);
    localparam int CNT_W        = 24;
    localparam int IDX_W        = 10;
    localparam int SCORE_W      = 32;
    localparam int NUM_W        = CNT_W + 2;
    localparam int LN_W         = 29;
    localparam int DVD_W        = 54;
    localparam int ROOT_W       = 27;
    localparam int UNIT_W       = 30;
    localparam int SREM_W       = 28;
    localparam int STEP_W       = 6;

    // Last iteration index of each loop of the shared compare/subtract unit
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DVD_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    // ln(1 + k/16) in Q0.24; the last entry is ln 2
    localparam logic [CNT_W-1:0] LN_TAB [17] = '{
        24'd0,       24'd1017112, 24'd1976072, 24'd2883169, 24'd3743728,
        24'd4562291, 24'd5342767, 24'd6088544, 24'd6802576, 24'd7487455,
        24'd8145470, 24'd8778647, 24'd9388795, 24'd9977529, 24'd10546303,
        24'd11096425, 24'd11629080
    };

    typedef enum logic [3:0] {
        C_IDLE, C_NORM, C_MUL, C_LNSUM, C_DIVA, C_SETQ, C_DIVQ, C_SETS,
        C_SQRT, C_SUM
    } t_core_state;

    typedef enum logic [1:0] {
        S_IDLE, S_CALC, S_EMIT
    } t_top_state;

    // Status of the score engine as seen by the selector
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage

// ===== hw/rtl/ucb1_child_selector.sv =====
// Top level of the UCB1 child selector: selection state, handshakes, output beat.
// Depends on ucb_pkg and ucb_core.
//
// Usage: children stream in on the input channel (i_valid / o_stall), one beat
// per child; i_last_child marks the final child of a selection. On that beat's
// completion one result beat leaves on the output channel (o_valid / i_stall)
// carrying the chosen position and whether it was an unvisited child.
// Scoring: a visited child is scored by an iterative engine that runs through
// one shared compare/subtract unit: up to 23 normalize steps for the log,
// two 54-step restoring divisions and a 27-step root. An unvisited child, or
// any child after one, is accepted without being scored.
// o_stall is high while a child is being scored and while a finished result
// waits for the output register to free up; a stalled output beat holds.
// Reset (synchronous, active low) clears the running best, the position
// counter, the unvisited flag and the output valid.
module ucb1_child_selector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ucb_pkg::CNT_W-1:0]   i_first_wins,
    input  logic [ucb_pkg::CNT_W-1:0]   i_second_wins,
    input  logic [ucb_pkg::CNT_W-1:0]   i_draws,
    input  logic [ucb_pkg::CNT_W-1:0]   i_visits,
    input  logic                        i_side_to_move,
    input  logic [ucb_pkg::CNT_W-1:0]   i_total_visits,
    input  logic                        i_last_child,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ucb_pkg::IDX_W-1:0]   o_chosen_index,
    output logic                        o_chose_unvisited
);
    import ucb_pkg::*;

    t_top_state r_state, n_state;

    logic [SCORE_W-1:0] r_best;
    logic [POS_W-1:0]   r_best_pos;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_cur_pos;
    logic               r_unv;
    logic               r_last;
    logic               r_ov;
    logic [IDX_W-1:0]   r_idx;
    logic               r_unv_o;

    logic               w_acc;
    logic               w_start;
    logic               w_emit;
    t_core_stat         w_stat;
    logic [SCORE_W-1:0] w_score;

    ucb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_wins   (i_side_to_move ? i_second_wins : i_first_wins),
        .i_draws  (i_draws),
        .i_visits (i_visits),
        .i_total  (i_total_visits),
        .o_stat   (w_stat),
        .o_score  (w_score)
    );

    assign w_acc   = i_valid && !o_stall;
    assign w_start = w_acc && !r_unv && (i_visits != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_CALC;
                end else if (w_acc && i_last_child) begin
                    n_state = S_EMIT;
                end
            end
            S_CALC: if (w_stat.done) n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT: if (w_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_stall = 1'b1;
        w_emit  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_EMIT:  w_emit  = !r_ov || !i_stall;
            default: ;
        endcase
    end

    assign o_valid           = r_ov;
    assign o_chosen_index    = r_idx;
    assign o_chose_unvisited = r_unv_o;

    // Control and selection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_best     <= '0;
            r_best_pos <= '0;
            r_pos      <= '0;
            r_unv      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (w_acc) begin
                r_pos <= r_pos + 1'b1;
                if (!r_unv && (i_visits == '0)) begin
                    r_unv      <= 1'b1;
                    r_best_pos <= r_pos;
                end
            end
            if (r_state == S_CALC && w_stat.done && (w_score > r_best)) begin
                r_best     <= w_score;
                r_best_pos <= r_cur_pos;
            end
            if (w_emit) begin
                r_ov       <= 1'b1;
                r_best     <= '0;
                r_best_pos <= '0;
                r_pos      <= '0;
                r_unv      <= 1'b0;
            end
        end
    end

    // Beat payload and per-child bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cur_pos <= r_pos;
            r_last    <= i_last_child;
        end
        if (w_emit) begin
            r_idx   <= IDX_W'(r_best_pos);
            r_unv_o <= r_unv;
        end
    end

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == S_CALC))
        else $error("score engine finished outside scoring state");

    a_no_score_after_unv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> !r_unv)
        else $error("child scored after an unvisited child");

    a_clear_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_pos == '0) && !r_unv && (r_best == '0) && r_ov)
        else $error("selection state not cleared on result");

    a_engine_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_stat.busy)
        else $error("score engine busy while selector idle");
endmodule

// ===== hw/rtl/ucb_cmpsub.sv =====
// Shared compare-and-subtract unit: one restoring step of division or root.
// Depends on ucb_pkg.
module ucb_cmpsub (
    input  logic [ucb_pkg::UNIT_W-1:0] i_a,
    input  logic [ucb_pkg::UNIT_W-1:0] i_b,
    output logic                       o_ge,
    output logic [ucb_pkg::UNIT_W-1:0] o_diff
);
    import ucb_pkg::*;

    logic [UNIT_W:0] w_sub;

    // Subtract once, take the borrow as the compare
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[UNIT_W];
    assign o_diff = w_sub[UNIT_W-1:0];
endmodule

// ===== hw/rtl/ucb_core.sv =====
// Score engine: log lookup, two restoring divisions and an integer root, the last
// three stepped through one shared compare/subtract unit. Depends on ucb_pkg, ucb_cmpsub.
module ucb_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ucb_pkg::CNT_W-1:0]  i_wins,
    input  logic [ucb_pkg::CNT_W-1:0]  i_draws,
    input  logic [ucb_pkg::CNT_W-1:0]  i_visits,
    input  logic [ucb_pkg::CNT_W-1:0]  i_total,
    output ucb_pkg::t_core_stat        o_stat,
    output logic [ucb_pkg::SCORE_W-1:0] o_score
);
    import ucb_pkg::*;

    t_core_state r_state, n_state;

    logic [CNT_W-1:0]   r_t;
    logic [4:0]         r_e;
    logic [NUM_W-1:0]   r_num;
    logic [CNT_W-1:0]   r_vis;
    logic [CNT_W-1:0]   r_frac;
    logic [LN_W-1:0]    r_eln;
    logic [LN_W-1:0]    r_ln;
    logic [DVD_W-1:0]   r_dvd;
    logic [CNT_W-1:0]   r_rem;
    logic [DVD_W-1:0]   r_quo;
    logic [SREM_W-1:0]  r_srem;
    logic [ROOT_W-1:0]  r_root;
    logic [SCORE_W-1:0] r_avg;
    logic [STEP_W-1:0]  r_cnt;

    logic [3:0]         w_k;
    logic [CNT_W-1:0]   w_base;
    logic [CNT_W-1:0]   w_dtab;
    logic [CNT_W+18:0]  w_prod;
    logic [CNT_W:0]     w_dcur;
    logic [UNIT_W-1:0]  w_scur;
    logic [ROOT_W+1:0]  w_trial;
    logic [UNIT_W-1:0]  w_ua;
    logic [UNIT_W-1:0]  w_ub;
    logic               w_ge;
    logic [UNIT_W-1:0]  w_diff;
    logic [SCORE_W:0]   w_sum;

    ucb_cmpsub u_unit (
        .i_a    (w_ua),
        .i_b    (w_ub),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    // Table segment and interpolation
    assign w_k    = r_t[22:19];
    assign w_base = LN_TAB[{1'b0, w_k}];
    assign w_dtab = LN_TAB[{1'b0, w_k} + 5'd1] - w_base;
    assign w_prod = w_dtab * r_t[18:0];

    // Partial remainders for divide and root
    assign w_dcur  = {r_rem, r_dvd[DVD_W-1]};
    assign w_scur  = {r_srem, r_dvd[DVD_W-1:DVD_W-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_sum   = {1'b0, r_avg} + (SCORE_W+1)'(r_root);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_start) n_state = C_NORM;
            C_NORM:  if (r_t[CNT_W-1]) n_state = C_MUL;
            C_MUL:   n_state = C_LNSUM;
            C_LNSUM: n_state = C_DIVA;
            C_DIVA:  if (r_cnt == DIV_LAST) n_state = C_SETQ;
            C_SETQ:  n_state = C_DIVQ;
            C_DIVQ:  if (r_cnt == DIV_LAST) n_state = C_SETS;
            C_SETS:  n_state = C_SQRT;
            C_SQRT:  if (r_cnt == SQRT_LAST) n_state = C_SUM;
            C_SUM:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // Outputs and operand selection for the shared unit
    always_comb begin
        o_stat.busy = (r_state != C_IDLE);
        o_stat.done = 1'b0;
        w_ua        = UNIT_W'(w_dcur);
        w_ub        = UNIT_W'(r_vis);
        unique case (r_state)
            C_SQRT: begin
                w_ua = w_scur;
                w_ub = UNIT_W'(w_trial);
            end
            C_SUM:   o_stat.done = 1'b1;
            default: ;
        endcase
    end

    // Saturated score, valid while done is high
    assign o_score = w_sum[SCORE_W] ? '1 : w_sum[SCORE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                r_t   <= (i_total == '0) ? CNT_W'(1) : i_total;
                r_e   <= 5'd23;
                r_num <= {1'b0, i_wins, 1'b0} + NUM_W'(i_draws);
                r_vis <= i_visits;
            end
            C_NORM: begin
                if (!r_t[CNT_W-1]) begin
                    r_t <= r_t << 1;
                    r_e <= r_e - 5'd1;
                end
            end
            C_MUL: begin
                r_frac <= w_prod[CNT_W+18:19];
                r_eln  <= LN_W'(r_e * LN_TAB[16]);
            end
            C_LNSUM: begin
                r_ln  <= r_eln + LN_W'(w_base) + LN_W'(r_frac);
                r_dvd <= DVD_W'({r_num, 23'b0});
                r_rem <= '0;
                r_cnt <= '0;
            end
            C_DIVA, C_DIVQ: begin
                r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_dcur[CNT_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            C_SETQ: begin
                r_avg <= (r_quo[DVD_W-1:SCORE_W] != '0) ? '1 : r_quo[SCORE_W-1:0];
                r_dvd <= {r_ln, 25'b0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            C_SETS: begin
                r_dvd  <= r_quo;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            C_SQRT: begin
                r_srem <= w_ge ? w_diff[SREM_W-1:0] : w_scur[SREM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_dvd  <= r_dvd << 2;
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end
endmodule
